// File: design/asdm_pkg.sv
// shared types, constants and coefficient table for the ambisonic decoder
package asdm_pkg;

  localparam int MAX_SPEAKERS   = 8;
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 14;

  localparam int NCH        = 16;
  localparam int NSETUPS    = 6;
  localparam int QB         = 28;
  localparam int COEF_BITS  = COEF_FRAC_BITS + 4;
  localparam int PROD_BITS  = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_BITS   = 48;
  localparam int SPK_BITS   = 3;
  localparam int CH_BITS    = 4;
  localparam int CNT_BITS   = 4;
  localparam int ROM_DEPTH  = NSETUPS * 2 * 8 * NCH;
  localparam int ROM_ABITS  = $clog2(ROM_DEPTH);

  // configuration register indexes
  localparam logic [1:0] CFG_SETUP  = 2'd0;
  localparam logic [1:0] CFG_PRESET = 2'd1;
  localparam logic [1:0] CFG_ORDER  = 2'd2;
  // index with no register behind it
  localparam logic [1:0] CFG_NONE   = 2'd3;

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef coef_t coef_rom_t [ROM_DEPTH];

  // controller to datapath commands
  typedef struct packed {
    logic                 sample_load;
    logic                 mac_issue;
    logic [ROM_ABITS-1:0] mac_addr;
    logic [SPK_BITS-1:0]  mac_spk;
    logic                 clear_acc;
    logic                 emit_load;
    logic [SPK_BITS-1:0]  emit_spk;
    logic                 emit_last;
    logic [CNT_BITS-1:0]  n_spk;
  } asdm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } asdm_stat_t;

  localparam longint ONE_Q = 64'sd1 << QB;
  localparam longint ROOT_HALF_Q = 189812531;
  localparam longint DC30 = 232471924;
  localparam longint DH   = 134217728;
  localparam longint DR   = 189812531;
  localparam longint DC70 = 91810333;
  localparam longint DS70 = 252246817;
  localparam longint DA   = 248002024;
  localparam longint DB   = 102725802;
  localparam longint DE   = 164382474;
  localparam longint DONE = 268435456;

  localparam int SPK_COUNT [NSETUPS] = '{2, 4, 5, 8, 8, 5};
  localparam int ROW_START [NSETUPS] = '{0, 2, 6, 11, 19, 27};

  // preset weights in units of 1e-4, columns w x y z r s t u v
  localparam int PRESET_TAB [32][9] = '{
    '{7071, 0, 5000, 0, 0, 0, 0, 0, 0}, '{7071, 0, -5000, 0, 0, 0, 0, 0, 0},
    '{3536, 2434, 2434, 0, 0, 0, 0, 0, 964}, '{3536, 2434, -2434, 0, 0, 0, 0, 0, -964},
    '{3536, -2434, -2434, 0, 0, 0, 0, 0, 964}, '{3536, -2434, 2434, 0, 0, 0, 0, 0, -964},
    '{2828, 2227, 1618, 0, 0, 0, 0, 238, 733}, '{2828, -851, 2619, 0, 0, 0, 0, -624, -453},
    '{2828, -2753, 0, 0, 0, 0, 0, 771, 0}, '{2828, -851, -2619, 0, 0, 0, 0, -624, 453},
    '{2828, 2227, -1618, 0, 0, 0, 0, 238, -733},
    '{1768, 1591, 659, 0, 0, 0, 0, 342, 342}, '{1768, 659, 1591, 0, 0, 0, 0, -342, 342},
    '{1768, -659, 1591, 0, 0, 0, 0, -342, -342}, '{1768, -1591, 659, 0, 0, 0, 0, 342, -342},
    '{1768, -1591, -659, 0, 0, 0, 0, 342, 342}, '{1768, -659, -1591, 0, 0, 0, 0, -342, 342},
    '{1768, 659, -1591, 0, 0, 0, 0, -342, -342}, '{1768, 1591, -659, 0, 0, 0, 0, 342, -342},
    '{1768, 1140, 1140, -1140, 0, -369, -369, 0, 369},
    '{1768, 1140, -1140, -1140, 0, -369, 369, 0, -369},
    '{1768, -1140, -1140, -1140, 0, 369, 369, 0, 369},
    '{1768, -1140, 1140, -1140, 0, 369, -369, 0, -369},
    '{1768, 1140, 1140, 1140, 0, 369, 369, 0, 369},
    '{1768, 1140, -1140, 1140, 0, 369, -369, 0, -369},
    '{1768, -1140, -1140, 1140, 0, -369, -369, 0, 369},
    '{1768, -1140, 1140, 1140, 0, -369, 369, 0, -369},
    '{4724, 7143, 7258, 0, 0, 0, 0, 0, 3456}, '{4724, 7143, -7258, 0, 0, 0, 0, 0, -3456},
    '{3226, 7719, 0, 0, 0, 0, 0, 0, 4724}, '{9101, -7834, 9562, 0, 0, 0, 0, -806, 0},
    '{9101, -7834, -9562, 0, 0, 0, 0, -806, 0}
  };

  // speaker direction vectors x y z at 28 fractional bits
  localparam longint DIR_TAB [27][3] = '{
    '{DC30, -DH, 0}, '{DC30, DH, 0},
    '{DR, DR, 0}, '{-DR, DR, 0}, '{-DR, -DR, 0}, '{DR, -DR, 0},
    '{DC30, -DH, 0}, '{DC30, DH, 0}, '{DONE, 0, 0}, '{-DC70, -DS70, 0}, '{-DC70, DS70, 0},
    '{DA, DB, 0}, '{DB, DA, 0}, '{-DB, DA, 0}, '{-DA, DB, 0},
    '{-DA, -DB, 0}, '{-DB, -DA, 0}, '{DB, -DA, 0}, '{DA, -DB, 0},
    '{DR, DR, 0}, '{DE, DE, DH}, '{-DR, DR, 0}, '{-DE, DE, DH},
    '{-DR, -DR, 0}, '{-DE, -DE, DH}, '{DR, -DR, 0}, '{DE, -DE, DH}
  };

  // round by s bits, to nearest, ties away from zero
  function automatic longint rnd_shift(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    if (s == 0) return v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint qm(input longint a, input longint b);
    return rnd_shift(a * b, QB);
  endfunction

  function automatic longint tenk_to_q(input int v);
    longint m;
    m = (v < 0) ? -v : v;
    m = ((m <<< QB) + 5000) / 10000;
    return (v < 0) ? -m : m;
  endfunction

  // coefficient table, address {setup-1, preset, speaker, channel}
  function automatic coef_rom_t build_rom();
    coef_rom_t rom;
    longint c [NCH];
    longint x, y, z, x2, y2, z2, ee, r;
    logic [63:0] rb;
    int base, addr;
    ee = (8 * ONE_Q + 5) / 11;
    for (int s = 0; s < NSETUPS; s++) begin
      base = ROW_START[s];
      for (int p = 0; p < 2; p++) begin
        for (int i = 0; i < 8; i++) begin
          for (int j = 0; j < NCH; j++) c[j] = 0;
          if (i < SPK_COUNT[s]) begin
            if (p == 1 || s == 5) begin
              for (int j = 0; j < 9; j++) c[j] = tenk_to_q(PRESET_TAB[base + i][j]);
              if (s == 0) c[0] = ROOT_HALF_Q;
            end else begin
              x  = DIR_TAB[base + i][0];
              y  = DIR_TAB[base + i][1];
              z  = DIR_TAB[base + i][2];
              x2 = qm(x, x);
              y2 = qm(y, y);
              z2 = qm(z, z);
              c[0]  = ROOT_HALF_Q;
              c[1]  = x;
              c[2]  = y;
              c[3]  = z;
              c[4]  = rnd_shift(3 * z2 - ONE_Q, 1);
              c[5]  = 2 * qm(x, z);
              c[6]  = 2 * qm(y, z);
              c[7]  = x2 - y2;
              c[8]  = 2 * qm(x, y);
              c[9]  = rnd_shift(qm(z, 5 * z2 - 3 * ONE_Q), 1);
              c[10] = qm(ee, qm(y, 5 * z2 - ONE_Q));
              c[11] = qm(ee, qm(x, 5 * z2 - ONE_Q));
              c[12] = 2 * qm(qm(x, y), z);
              c[13] = qm(z, x2 - y2);
              c[14] = 3 * qm(y, 3 * x2 - y2);
              c[15] = 3 * qm(x, x2 - 3 * y2);
            end
          end
          for (int j = 0; j < NCH; j++) begin
            r    = rnd_shift(c[j], QB - COEF_FRAC_BITS);
            rb   = r;
            addr = ((s * 2 + p) * 8 + i) * NCH + j;
            rom[addr] = rb[COEF_BITS-1:0];
          end
        end
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t COEF_ROM = build_rom();

endpackage

// File: design/asdm_ctrl.sv
// frame sequencer: configuration, channel position, mac and emit control
module asdm_ctrl import asdm_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [2:0]             cfg_data_i,
  input  asdm_stat_t             stat_i,
  output asdm_cmd_t              cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAC  = 3'b010,
    S_EMIT = 3'b100
  } state_e;

  state_e               state_q, state_d;
  logic [2:0]           setup_q, setup_d;
  logic                 preset_q, preset_d;
  logic [1:0]           order_q, order_d;
  logic [CH_BITS-1:0]   pos_q, pos_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic [SPK_BITS-1:0]  spk_q, spk_d;

  logic [2:0]           sel_idx;
  logic                 pre_eff;
  logic [CNT_BITS-1:0]  n_spk;
  logic [CH_BITS:0]     frame_len;
  logic                 accept;
  logic                 cfg_hit;

  // effective setup, speaker count and frame length
  always_comb begin
    unique case (setup_q)
      3'd0, 3'd1: sel_idx = 3'd0;
      3'd2:       sel_idx = 3'd1;
      3'd3:       sel_idx = 3'd2;
      3'd4:       sel_idx = 3'd3;
      3'd5:       sel_idx = 3'd4;
      default:    sel_idx = 3'd5;
    endcase
    pre_eff = preset_q | (sel_idx == 3'd5);
    n_spk   = CNT_BITS'(SPK_COUNT[sel_idx]);
    unique case (order_q)
      2'd3:    frame_len = (CH_BITS+1)'(16);
      2'd2:    frame_len = (CH_BITS+1)'(9);
      default: frame_len = (CH_BITS+1)'(4);
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign cfg_hit    = cfg_we_i & (cfg_index_i != CFG_NONE);

  // next state and commands
  always_comb begin
    state_d  = state_q;
    setup_d  = setup_q;
    preset_d = preset_q;
    order_d  = order_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    spk_d    = spk_q;
    cmd_o    = '0;
    cmd_o.n_spk    = n_spk;
    cmd_o.mac_spk  = cnt_q[SPK_BITS-1:0];
    cmd_o.mac_addr = {sel_idx, pre_eff, cnt_q[SPK_BITS-1:0], pos_q};
    cmd_o.emit_spk = spk_q;
    cmd_o.emit_last = ({1'b0, spk_q} == n_spk - CNT_BITS'(1));

    if (cfg_hit) begin
      unique case (cfg_index_i)
        CFG_SETUP:  setup_d  = cfg_data_i;
        CFG_PRESET: preset_d = cfg_data_i[0];
        CFG_ORDER:  order_d  = cfg_data_i[1:0];
        default:    ;
      endcase
      pos_d = '0;
      cmd_o.clear_acc = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.sample_load = 1'b1;
          cnt_d   = '0;
          state_d = S_MAC;
        end
      end
      S_MAC: begin
        cmd_o.mac_issue = (cnt_q < n_spk);
        cnt_d = cnt_q + CNT_BITS'(1);
        if (cnt_q == n_spk + CNT_BITS'(1)) begin
          if ({1'b0, pos_q} + (CH_BITS+1)'(1) == frame_len) begin
            pos_d   = '0;
            spk_d   = '0;
            state_d = S_EMIT;
          end else begin
            pos_d   = pos_q + CH_BITS'(1);
            state_d = S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (cmd_o.emit_last) begin
            cmd_o.clear_acc = 1'b1;
            state_d = S_IDLE;
          end else begin
            spk_d = spk_q + SPK_BITS'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      setup_q  <= 3'd1;
      preset_q <= 1'b0;
      order_q  <= 2'd1;
      pos_q    <= '0;
      cnt_q    <= '0;
      spk_q    <= '0;
    end else begin
      state_q  <= state_d;
      setup_q  <= setup_d;
      preset_q <= preset_d;
      order_q  <= order_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      spk_q    <= spk_d;
    end
  end

endmodule

// File: design/asdm_datapath.sv
// coefficient lookup, shared multiplier, accumulators and output register
module asdm_datapath import asdm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  asdm_cmd_t                     cmd_i,
  output asdm_stat_t                    stat_o,
  output logic signed [SAMPLE_BITS-1:0] speaker_sample_o,
  output logic [SPK_BITS-1:0]           speaker_index_o,
  output logic                          last_speaker_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);

  localparam int RND_BITS = ACC_BITS - COEF_FRAC_BITS;
  localparam logic signed [RND_BITS-1:0] SMAX = RND_BITS'((64'sd1 <<< (SAMPLE_BITS-1)) - 1);
  localparam logic signed [RND_BITS-1:0] SMIN = -SMAX - RND_BITS'(1);

  logic signed [SAMPLE_BITS-1:0] sample_q;
  coef_t                         coef_q;
  logic                          v1_q, v2_q;
  logic [SPK_BITS-1:0]           spk1_q, spk2_q;
  logic signed [PROD_BITS-1:0]   prod_q;
  logic signed [ACC_BITS-1:0]    acc_q [MAX_SPEAKERS];

  logic signed [SAMPLE_BITS-1:0] out_sample_q;
  logic [SPK_BITS-1:0]           out_spk_q;
  logic                          out_last_q;
  logic                          out_valid_q;

  logic signed [ACC_BITS-1:0]    acc_sel;
  logic signed [ACC_BITS-1:0]    acc_rnd;
  logic signed [RND_BITS-1:0]    rnd_val;
  logic signed [SAMPLE_BITS-1:0] sat_val;

  // sample capture, coefficient read and product stages
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) sample_q <= sample_value_i;
    coef_q <= COEF_ROM[cmd_i.mac_addr];
    spk1_q <= cmd_i.mac_spk;
    prod_q <= PROD_BITS'(sample_q) * PROD_BITS'(coef_q);
    spk2_q <= spk1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  // accumulate, cleared per frame and on configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SPEAKERS; i++) acc_q[i] <= '0;
    end else if (cmd_i.clear_acc) begin
      for (int i = 0; i < MAX_SPEAKERS; i++) acc_q[i] <= '0;
    end else if (v2_q) begin
      acc_q[spk2_q] <= acc_q[spk2_q] + ACC_BITS'(prod_q);
    end
  end

  // round to nearest with ties away from zero, then saturate
  always_comb begin
    acc_sel = acc_q[cmd_i.emit_spk];
    acc_rnd = acc_sel + ACC_BITS'(64'sd1 <<< (COEF_FRAC_BITS-1))
              - ACC_BITS'(acc_sel[ACC_BITS-1]);
    rnd_val = acc_rnd[ACC_BITS-1:COEF_FRAC_BITS];
    if (rnd_val > SMAX)      sat_val = SMAX[SAMPLE_BITS-1:0];
    else if (rnd_val < SMIN) sat_val = SMIN[SAMPLE_BITS-1:0];
    else                     sat_val = rnd_val[SAMPLE_BITS-1:0];
  end

  assign stat_o.out_free = ~out_valid_q | ~out_stall_i;

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_sample_q <= sat_val;
      out_spk_q    <= cmd_i.emit_spk;
      out_last_q   <= cmd_i.emit_last;
    end
  end

  assign speaker_sample_o = out_sample_q;
  assign speaker_index_o  = out_spk_q;
  assign last_speaker_o   = out_last_q;
  assign out_valid_o      = out_valid_q;

endmodule

// File: design/ambisonic_speaker_decoder_matrix.sv
// ambisonic b-format decoder: one shared multiplier over all speakers
// each channel sample passes once per speaker through the coefficient
//   read, multiply and accumulate stages of the single multiplier
// the input stalls while a sample is accumulated; a frame end adds an emit phase
// outputs leave one per cycle through the output register when not stalled
// reset: setup 1, direction weights, order 1, accumulators and position zero
module ambisonic_speaker_decoder_matrix import asdm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic signed [SAMPLE_BITS-1:0] speaker_sample_o,
  output logic [SPK_BITS-1:0]           speaker_index_o,
  output logic                          last_speaker_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [2:0]                    cfg_data_i
);

  asdm_cmd_t  cmd;
  asdm_stat_t stat;

  asdm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  asdm_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .sample_value_i   (sample_value_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .speaker_sample_o (speaker_sample_o),
    .speaker_index_o  (speaker_index_o),
    .last_speaker_o   (last_speaker_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

  // an accepted transaction occupies the sequencer next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while sequencer busy");

  // the frame's final speaker carries the last flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit_load |-> (cmd.emit_last == ({1'b0, cmd.emit_spk} == cmd.n_spk - 4'd1)))
    else $error("last flag not on final speaker");

  // no emit while multiply-accumulate stages are issuing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.emit_load && cmd.mac_issue))
    else $error("emit overlaps accumulate");

endmodule

// File: bench/asdm_checker.sv
// decoder checker: mirrors the decode matrix and compares speaker transactions
`timescale 1ns / 100ps
module asdm_checker import asdm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic signed [SAMPLE_BITS-1:0] sample_value_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic signed [SAMPLE_BITS-1:0] speaker_sample_i,
  input  logic [SPK_BITS-1:0]           speaker_index_i,
  input  logic                          last_speaker_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [2:0]                    cfg_data_i,
  output int                            pending_o,
  output int                            errors_o
);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SPK_BITS-1:0]           index;
    logic                          last;
  } spk_out_t;

  localparam longint SMAX = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;

  spk_out_t   speaker_q [$];
  logic [2:0] layout_r;
  logic       preset_r;
  logic [1:0] order_r;
  longint     weight [8][NCH];
  longint     mix_acc [8];
  int         chan_pos;
  int         err_cnt;

  assign pending_o = speaker_q.size();
  assign errors_o  = err_cnt;

  // round by s bits to nearest, ties away from zero
  function automatic longint round_away(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    if (s == 0) return v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return round_away(a * b, QB);
  endfunction

  function automatic longint tenk_q(input int v);
    longint m;
    m = (v < 0) ? -v : v;
    m = ((m <<< QB) + 5000) / 10000;
    return (v < 0) ? -m : m;
  endfunction

  function automatic int layout_sel();
    if (layout_r == 3'd0) return 1;
    if (layout_r == 3'd7) return 6;
    return int'(layout_r);
  endfunction

  function automatic int frame_channels();
    if (order_r == 2'd3) return 16;
    if (order_r == 2'd2) return 9;
    return 4;
  endfunction

  // rebuild the per-speaker weight matrix from the current registers
  task automatic load_weights();
    longint c [NCH];
    longint x, y, z, x2, y2, z2, ee;
    int sel, base, nspk;
    sel  = layout_sel();
    base = ROW_START[sel-1];
    nspk = SPK_COUNT[sel-1];
    ee   = (8 * ONE_Q + 5) / 11;
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < NCH; j++) c[j] = 0;
      if (i < nspk) begin
        if (preset_r || sel == 6) begin
          for (int j = 0; j < 9; j++) c[j] = tenk_q(PRESET_TAB[base+i][j]);
          if (sel == 1) c[0] = ROOT_HALF_Q;
        end else begin
          x = DIR_TAB[base+i][0];
          y = DIR_TAB[base+i][1];
          z = DIR_TAB[base+i][2];
          x2 = qmul(x, x);
          y2 = qmul(y, y);
          z2 = qmul(z, z);
          c[0]  = ROOT_HALF_Q;
          c[1]  = x;
          c[2]  = y;
          c[3]  = z;
          c[4]  = round_away(3 * z2 - ONE_Q, 1);
          c[5]  = 2 * qmul(x, z);
          c[6]  = 2 * qmul(y, z);
          c[7]  = x2 - y2;
          c[8]  = 2 * qmul(x, y);
          c[9]  = round_away(qmul(z, 5 * z2 - 3 * ONE_Q), 1);
          c[10] = qmul(ee, qmul(y, 5 * z2 - ONE_Q));
          c[11] = qmul(ee, qmul(x, 5 * z2 - ONE_Q));
          c[12] = 2 * qmul(qmul(x, y), z);
          c[13] = qmul(z, x2 - y2);
          c[14] = 3 * qmul(y, 3 * x2 - y2);
          c[15] = 3 * qmul(x, x2 - 3 * y2);
        end
      end
      for (int j = 0; j < NCH; j++) weight[i][j] = round_away(c[j], QB - COEF_FRAC_BITS);
    end
  endtask

  task automatic clear_mix();
    for (int i = 0; i < 8; i++) mix_acc[i] = 0;
    chan_pos = 0;
  endtask

  task automatic report(input string msg);
    $display("checker: %s", msg);
    err_cnt++;
  endtask

  // accumulate one channel sample, queue speaker outputs at frame end
  task automatic decode_sample(input logic signed [SAMPLE_BITS-1:0] s);
    int nspk;
    longint v;
    spk_out_t e;
    nspk = SPK_COUNT[layout_sel()-1];
    for (int i = 0; i < nspk; i++) mix_acc[i] += longint'(s) * weight[i][chan_pos];
    chan_pos++;
    if (chan_pos >= frame_channels()) begin
      for (int i = 0; i < nspk; i++) begin
        v = round_away(mix_acc[i], COEF_FRAC_BITS);
        if (v > SMAX) v = SMAX;
        if (v < -SMAX - 1) v = -SMAX - 1;
        e.sample = v[SAMPLE_BITS-1:0];
        e.index  = i[SPK_BITS-1:0];
        e.last   = (i == nspk - 1);
        speaker_q.push_back(e);
      end
      clear_mix();
    end
  endtask

  // watch config, input and output channels
  always @(posedge clk_i or negedge rst_ni) begin
    spk_out_t e;
    if (!rst_ni) begin
      layout_r = 3'd1;
      preset_r = 1'b0;
      order_r  = 2'd1;
      clear_mix();
      load_weights();
      speaker_q.delete();
    end else begin
      if (cfg_we_i && cfg_index_i != CFG_NONE) begin
        case (cfg_index_i)
          CFG_SETUP:  layout_r = cfg_data_i;
          CFG_PRESET: preset_r = cfg_data_i[0];
          CFG_ORDER:  order_r  = cfg_data_i[1:0];
          default: ;
        endcase
        clear_mix();
        load_weights();
      end
      if (in_valid_i && !in_stall_i) decode_sample(sample_value_i);
      if (out_valid_i && !out_stall_i) begin
        if (speaker_q.size() == 0) begin
          report("unexpected speaker transaction");
        end else begin
          e = speaker_q.pop_front();
          if (speaker_sample_i !== e.sample)
            report($sformatf("sample %0d, expected %0d", speaker_sample_i, e.sample));
          if (speaker_index_i !== e.index)
            report($sformatf("index %0d, expected %0d", speaker_index_i, e.index));
          if (last_speaker_i !== e.last)
            report($sformatf("last %0b, expected %0b", last_speaker_i, e.last));
        end
      end
    end
  end

  initial err_cnt = 0;

endmodule

// File: bench/tb.sv
// decoder testbench top: stimulus, idling phases, watchdog and verdict
`timescale 1ns / 100ps
module tb;
  import asdm_pkg::*;

  localparam int SETTLE = 24;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_value_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] speaker_sample_o;
  logic [SPK_BITS-1:0]           speaker_index_o;
  logic                          last_speaker_o;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [1:0]                    cfg_index_i = '0;
  logic [2:0]                    cfg_data_i = '0;
  int                            pending;
  int                            errors;
  int                            gap_pct = 0;
  int                            stall_pct = 0;
  int                            idle_cycles = 0;
  int                            sent = 0;
  logic [1:0]                    cur_order = 2'd1;

  ambisonic_speaker_decoder_matrix dut (.*);

  asdm_checker checker_i (
    .clk_i, .rst_ni, .sample_value_i, .in_valid_i, .in_stall_i(in_stall_o),
    .speaker_sample_i(speaker_sample_o), .speaker_index_i(speaker_index_o),
    .last_speaker_i(last_speaker_o), .out_valid_i(out_valid_o), .out_stall_i,
    .cfg_we_i, .cfg_index_i, .cfg_data_i, .pending_o(pending), .errors_o(errors)
  );

  always #1 clk_i = ~clk_i;

  // receiver stall
  always @(negedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // stall is read at the falling edge, where it holds its value for the next rising edge
  task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] v);
    logic stalled;
    @(negedge clk_i);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sample_value_i <= v;
    stalled = in_stall_o;
    @(posedge clk_i);
    while (stalled) begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end
    sent++;
  endtask

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(7))
      0: return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      1: return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // wait until all speaker transactions have drained, then settle
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    if (idx == CFG_ORDER) cur_order = val[1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int frame_channels();
    if (cur_order == 2'd3) return 16;
    if (cur_order == 2'd2) return 9;
    return 4;
  endfunction

  task automatic send_frame();
    for (int k = 0; k < frame_channels(); k++) send_sample(rand_sample());
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: full scale frames at reset settings, then small codes, then setup 7 and preset writes
    for (int k = 0; k < 4; k++) send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    for (int k = 0; k < 4; k++) send_sample({1'b1, {(SAMPLE_BITS-1){1'b0}}});
    send_sample(24'sd1); send_sample(-24'sd1); send_sample('0); send_sample(24'sd3);
    drain();
    write_reg(CFG_SETUP, 3'd7);
    write_reg(CFG_ORDER, 3'd0);
    write_reg(CFG_NONE, 3'd5);
    for (int k = 0; k < 4; k++) send_sample({1'b0, {(SAMPLE_BITS-1){1'b1}}});
    drain();
    write_reg(CFG_SETUP, 3'd0);
    write_reg(CFG_PRESET, 3'd1);
    write_reg(CFG_ORDER, 3'd3);
    send_sample(24'sd1000);
    send_sample(-24'sd1000);
    drain();

    // random: three idling phases, random settings between frames
    for (int ph = 0; ph < 3; ph++) begin
      gap_pct   = (ph == 0) ? 10 : (ph == 1) ? 53 : 0;
      stall_pct = (ph == 0) ? 53 : (ph == 1) ? 10 : 0;
      while (sent < (ph + 1) * 160) begin
        write_reg(CFG_SETUP, 3'($urandom_range(7)));
        write_reg(CFG_PRESET, 3'($urandom_range(1)));
        write_reg(CFG_ORDER, 3'($urandom_range(3)));
        repeat ($urandom_range(3, 1)) send_frame();
        // occasionally leave a frame unfinished, dropped by the next write
        if ($urandom_range(4) == 0)
          for (int k = 0; k < $urandom_range(frame_channels() - 1, 1); k++)
            send_sample(rand_sample());
        drain();
      end
    end

    if (errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
